// ===== src/camera_basis_from_yaw_pitch_macros.svh =====
// Assertion macros for the camera basis block.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef CAMERA_BASIS_FROM_YAW_PITCH_MACROS_SVH
`define CAMERA_BASIS_FROM_YAW_PITCH_MACROS_SVH

// Implication checked in the same cycle.
`define CBYP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle.
`define CBYP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/cbyp_pkg.sv =====
// Shared types and constants for the camera basis block.
// No dependencies.
package cbyp_pkg;

  typedef struct packed {
    logic signed [15:0] yaw_angle;
    logic signed [15:0] pitch_angle;
  } in_t;

  typedef struct packed {
    logic signed [15:0] front_x;
    logic signed [15:0] front_y;
    logic signed [15:0] front_z;
    logic signed [15:0] right_x;
    logic signed [15:0] right_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
    logic               degenerate;
  } out_t;

  // One CORDIC lane: Q30 vector, residual angle, quadrant and exact-quadrant flag.
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic [1:0]         quad;
    logic               exact;
  } lane_t;

  localparam logic signed [33:0] ONE_Q30      = 34'sd1073741824;
  localparam logic signed [33:0] GAIN_INV_Q30 = 34'sd652032874;

  // atan(2^-i), full turn = 2^32
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

endpackage

// ===== src/cbyp_reduce.sv =====
// Angle reduction: degrees -> quadrant and Q30 binary angle, five stages.
// Depends on cbyp_pkg.
module cbyp_reduce #(
  parameter int ANGLE_FRAC_BITS = 6
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [15:0]     angle_i,
  output cbyp_pkg::lane_t        lane_o
);
  import cbyp_pkg::*;

  localparam int FULL    = 360 << ANGLE_FRAC_BITS;
  localparam int QUARTER = 90 << ANGLE_FRAC_BITS;
  localparam int OFF     = FULL * ((32768 + FULL - 1) / FULL);
  localparam int UW      = $clog2(32767 + OFF + 1);
  localparam int LW      = $clog2(FULL);
  localparam int RMW     = UW + 1;
  localparam longint unsigned RM = ((64'd1 << (UW + LW)) + FULL - 1) / FULL;
  localparam int KW      = RMW - LW;
  localparam int RW      = $clog2(QUARTER);
  // reciprocal of 45 for 36-bit numerators, shift 42
  localparam logic [36:0] ZM    = 37'd97734366914;
  localparam logic [17:0] ZM_HI = ZM[36:19];
  localparam logic [18:0] ZM_LO = ZM[18:0];
  localparam logic [79:0] Z22M  = 80'(ZM) * 80'd22;

  localparam logic [UW-1:0] FULL_U = UW'(FULL);
  localparam logic [LW-1:0] Q1 = LW'(QUARTER);
  localparam logic [LW-1:0] Q2 = LW'(2 * QUARTER);
  localparam logic [LW-1:0] Q3 = LW'(3 * QUARTER);

  // stage 1
  logic [UW-1:0]     u_d, u_q;
  logic [UW+RMW-1:0] kp_d, kp_q;
  logic signed [UW:0] us;
  // stage 2
  logic [KW-1:0] k;
  logic [UW-1:0] r_full;
  logic [LW-1:0] r_q;
  // stage 3
  logic [1:0]    q_d, q3_q, q4_q, q5_q;
  logic [LW-1:0] rem_full;
  logic [RW-1:0] rem_q;
  logic          ex3_q, ex4_q, ex5_q;
  // stage 4
  logic [RW+17:0] phi_q;
  logic [RW+18:0] plo_q;
  // stage 5
  logic [79:0] rm, zsum;
  logic [30:0] z_q;

  always_comb begin
    us   = (UW+1)'(angle_i) + (UW+1)'(OFF);
    u_d  = us[UW-1:0];
    kp_d = (UW+RMW)'(u_d) * (UW+RMW)'(RM);
    k      = kp_q[UW+RMW-1:UW+LW];
    r_full = u_q - UW'(k) * FULL_U;
    if (r_q >= Q3) begin
      q_d = 2'd3; rem_full = r_q - Q3;
    end else if (r_q >= Q2) begin
      q_d = 2'd2; rem_full = r_q - Q2;
    end else if (r_q >= Q1) begin
      q_d = 2'd1; rem_full = r_q - Q1;
    end else begin
      q_d = 2'd0; rem_full = r_q;
    end
    rm   = (80'(phi_q) << 19) + 80'(plo_q);
    zsum = (rm << (29 - ANGLE_FRAC_BITS)) + Z22M;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q   <= u_d;
      kp_q  <= kp_d;
      r_q   <= r_full[LW-1:0];
      q3_q  <= q_d;
      rem_q <= rem_full[RW-1:0];
      ex3_q <= (rem_full == '0);
      q4_q  <= q3_q;
      ex4_q <= ex3_q;
      phi_q <= (RW+18)'(rem_q) * (RW+18)'(ZM_HI);
      plo_q <= (RW+19)'(rem_q) * (RW+19)'(ZM_LO);
      q5_q  <= q4_q;
      ex5_q <= ex4_q;
      z_q   <= zsum[72:42];
    end
  end

  assign lane_o.x     = GAIN_INV_Q30;
  assign lane_o.y     = '0;
  assign lane_o.z     = signed'(34'(z_q));
  assign lane_o.quad  = q5_q;
  assign lane_o.exact = ex5_q;

endmodule

// ===== src/cbyp_cordic_cell.sv =====
// One rotation-mode CORDIC iteration with its output register.
// Depends on cbyp_pkg.
module cbyp_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  cbyp_pkg::lane_t lane_i,
  output cbyp_pkg::lane_t lane_o
);
  import cbyp_pkg::*;

  localparam logic signed [33:0] ATAN = signed'(34'(ATAN_TAB[IDX]));

  lane_t lane_d, lane_q;
  logic signed [33:0] dx, dy;

  always_comb begin
    dx     = lane_i.y >>> IDX;
    dy     = lane_i.x >>> IDX;
    lane_d = lane_i;
    if (!lane_i.z[33]) begin
      lane_d.x = lane_i.x - dx;
      lane_d.y = lane_i.y + dy;
      lane_d.z = lane_i.z - ATAN;
    end else begin
      lane_d.x = lane_i.x + dx;
      lane_d.y = lane_i.y - dy;
      lane_d.z = lane_i.z + ATAN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

// ===== src/cbyp_post.sv =====
// Quadrant mapping, basis products, rounding and saturation; four stages.
// Depends on cbyp_pkg.
module cbyp_post #(
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  cbyp_pkg::lane_t yaw_i,
  input  cbyp_pkg::lane_t pitch_i,
  output cbyp_pkg::out_t  out_o
);
  import cbyp_pkg::*;

  localparam int SH = 30 - OUT_FRAC_BITS;
  localparam logic signed [33:0] RND = (34'sd1 <<< SH) >>> 1;
  localparam logic signed [63:0] HALF_Q30 = 64'sd536870912;

  function automatic logic signed [31:0] clamp_unit(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > ONE_Q30) r = 32'(ONE_Q30);
    else if (v < -ONE_Q30) r = 32'(-ONE_Q30);
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [15:0] to_out(input logic signed [32:0] v);
    logic signed [33:0] t;
    logic signed [15:0] r;
    t = (34'(v) + RND) >>> SH;
    if (t > 34'sd32767) r = 16'sh7fff;
    else if (t < -34'sd32768) r = 16'sh8000;
    else r = t[15:0];
    return r;
  endfunction

  function automatic logic signed [32:0] rnd_q30(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + HALF_Q30) >>> 30;
    return t[32:0];
  endfunction

  // stage 1
  logic signed [31:0] cy_d, sy_d, cp_d, sp_d;
  logic signed [31:0] cy_q, sy_q, cp_q, sp_q;
  logic signed [31:0] ccy, ssy, ccp, ssp;
  // stage 2
  logic signed [63:0] pcc_q, psc_q, pcs_q, pss_q;
  logic signed [31:0] cy2_q, sy2_q, cp2_q, sp2_q;
  // stage 3
  logic signed [32:0] v_d [8];
  logic signed [32:0] v_q [8];
  logic               dg_d, dg_q;
  logic signed [32:0] mcc, msc, mcs, mss, cy3, sy3, cp3, sp3;
  logic               pos;
  // stage 4
  out_t out_q;

  always_comb begin
    ccy = yaw_i.exact   ? 32'(ONE_Q30) : clamp_unit(yaw_i.x);
    ssy = yaw_i.exact   ? '0           : clamp_unit(yaw_i.y);
    ccp = pitch_i.exact ? 32'(ONE_Q30) : clamp_unit(pitch_i.x);
    ssp = pitch_i.exact ? '0           : clamp_unit(pitch_i.y);
    case (yaw_i.quad)
      2'd0:    begin cy_d = ccy;  sy_d = ssy;  end
      2'd1:    begin cy_d = -ssy; sy_d = ccy;  end
      2'd2:    begin cy_d = -ccy; sy_d = -ssy; end
      default: begin cy_d = ssy;  sy_d = -ccy; end
    endcase
    case (pitch_i.quad)
      2'd0:    begin cp_d = ccp;  sp_d = ssp;  end
      2'd1:    begin cp_d = -ssp; sp_d = ccp;  end
      2'd2:    begin cp_d = -ccp; sp_d = -ssp; end
      default: begin cp_d = ssp;  sp_d = -ccp; end
    endcase
  end

  always_comb begin
    mcc = rnd_q30(pcc_q);
    msc = rnd_q30(psc_q);
    mcs = rnd_q30(pcs_q);
    mss = rnd_q30(pss_q);
    cy3 = 33'(cy2_q);
    sy3 = 33'(sy2_q);
    cp3 = 33'(cp2_q);
    sp3 = 33'(sp2_q);
    pos  = !cp2_q[31];
    dg_d = (cp2_q == '0);
    v_d[0] = mcc;
    v_d[1] = sp3;
    v_d[2] = msc;
    v_d[3] = pos ? -sy3 : sy3;
    v_d[4] = pos ? cy3 : -cy3;
    v_d[5] = pos ? -mcs : mcs;
    v_d[6] = pos ? cp3 : -cp3;
    v_d[7] = pos ? -mss : mss;
    if (dg_d) begin
      for (int i = 3; i < 8; i++) v_d[i] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cy_q  <= cy_d;
      sy_q  <= sy_d;
      cp_q  <= cp_d;
      sp_q  <= sp_d;
      pcc_q <= 64'(cy_q) * 64'(cp_q);
      psc_q <= 64'(sy_q) * 64'(cp_q);
      pcs_q <= 64'(cy_q) * 64'(sp_q);
      pss_q <= 64'(sy_q) * 64'(sp_q);
      cy2_q <= cy_q;
      sy2_q <= sy_q;
      cp2_q <= cp_q;
      sp2_q <= sp_q;
      v_q   <= v_d;
      dg_q  <= dg_d;
      out_q.front_x    <= to_out(v_q[0]);
      out_q.front_y    <= to_out(v_q[1]);
      out_q.front_z    <= to_out(v_q[2]);
      out_q.right_x    <= to_out(v_q[3]);
      out_q.right_z    <= to_out(v_q[4]);
      out_q.up_x       <= to_out(v_q[5]);
      out_q.up_y       <= to_out(v_q[6]);
      out_q.up_z       <= to_out(v_q[7]);
      out_q.degenerate <= dg_q;
    end
  end

  assign out_o = out_q;

endmodule

// ===== src/camera_basis_from_yaw_pitch.sv =====
// Camera basis from yaw and pitch: a pipeline that takes one angle-pair transaction
// per cycle while not stalled and returns front, right and up in Q(OUT_FRAC_BITS)
// through five stages of angle reduction, one CORDIC cell per iteration for each
// angle, and four stages of products, rounding and output.
// The last stage is the output register; the whole pipeline holds while a
// result waits on out_stall_i, so in_stall_o follows out_stall_i in that case.
// Depends on cbyp_pkg, cbyp_reduce, cbyp_cordic_cell, cbyp_post, camera_basis_from_yaw_pitch_macros.svh.
`include "camera_basis_from_yaw_pitch_macros.svh"

module camera_basis_from_yaw_pitch #(
  parameter int ANGLE_FRAC_BITS = 6,
  parameter int OUT_FRAC_BITS   = 14,
  parameter int CORDIC_STEPS    = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  cbyp_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output cbyp_pkg::out_t out_data_o
);
  import cbyp_pkg::*;

  localparam int DEPTH = 9 + CORDIC_STEPS;

  logic              adv;
  logic [DEPTH-1:0]  vld_d, vld_q;
  lane_t             yaw_lane   [CORDIC_STEPS+1];
  lane_t             pitch_lane [CORDIC_STEPS+1];

  assign adv        = !vld_q[DEPTH-1] || !out_stall_i;
  assign in_stall_o = !adv;
  assign vld_d      = {vld_q[DEPTH-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  cbyp_reduce #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_red_yaw (
    .clk_i   (clk_i),
    .en_i    (adv),
    .angle_i (in_data_i.yaw_angle),
    .lane_o  (yaw_lane[0])
  );

  cbyp_reduce #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_red_pitch (
    .clk_i   (clk_i),
    .en_i    (adv),
    .angle_i (in_data_i.pitch_angle),
    .lane_o  (pitch_lane[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    cbyp_cordic_cell #(.IDX(i)) u_cell_yaw (
      .clk_i  (clk_i),
      .en_i   (adv),
      .lane_i (yaw_lane[i]),
      .lane_o (yaw_lane[i+1])
    );
    cbyp_cordic_cell #(.IDX(i)) u_cell_pitch (
      .clk_i  (clk_i),
      .en_i   (adv),
      .lane_i (pitch_lane[i]),
      .lane_o (pitch_lane[i+1])
    );
  end

  cbyp_post #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_post (
    .clk_i   (clk_i),
    .en_i    (adv),
    .yaw_i   (yaw_lane[CORDIC_STEPS]),
    .pitch_i (pitch_lane[CORDIC_STEPS]),
    .out_o   (out_data_o)
  );

  assign out_valid_o = vld_q[DEPTH-1];

  `CBYP_ASSERT_NOW(a_stall_cause, in_stall_o, out_valid_o && out_stall_i, "stall without held result")
  `CBYP_ASSERT_NEXT(a_hold_valid, !adv, $stable(vld_q), "valid chain moved while held")
  `CBYP_ASSERT_NOW(a_degen_zero, out_valid_o && out_data_o.degenerate, out_data_o.right_x == 16'sd0 && out_data_o.right_z == 16'sd0 && out_data_o.up_x == 16'sd0 && out_data_o.up_y == 16'sd0 && out_data_o.up_z == 16'sd0, "degenerate basis not zero")
  `CBYP_ASSERT_NOW(a_up_y_sign, out_valid_o, !out_data_o.up_y[15], "up_y negative")

endmodule
